// ----- rtl/core/clb_pkg.sv -----
`default_nettype none

package clb_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 32;
  localparam int CAP_W               = 6;
  localparam int ELEM_W              = 32;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 6'd5;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP_TAIL = 3'd1,
    OP_POP_HEAD = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_ERASE    = 3'd4,
    OP_DUMP     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [ELEM_W-1:0] element_value;
    logic [4:0]               position;
    logic [5:0]               end_position;
  } clb_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [5:0]               count;
    logic                     is_empty;
    logic signed [ELEM_W-1:0] element_out;
    logic                     element_valid;
    logic                     last;
  } clb_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/compacting_list_buffer.sv -----
`default_nettype none
// Push, pops, errors and unused commands go to S_RESP and load the result once the output is free.
// Deletes: S_SHIFT reads each kept entry at src and writes it back at dst, then S_RESP loads the result.
// Dump: per element one memory read (S_DUMP_RD), then the output register load (S_DUMP_WAIT),
// which waits while the output stalls; an empty dump answers through S_RESP. One command at a time.
// Reset: sync, active high; count 0, capacity 5, output empty. Memory is not cleared.

module compacting_list_buffer #(
  parameter int MAX_ENTRIES = clb_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  clb_pkg::clb_cmd_t             cmd,
  output logic                          res_valid,
  input  logic                          res_stall,
  output clb_pkg::clb_res_t             res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clb_pkg::CAP_W-1:0]     cfg_data
);

  import clb_pkg::*;

  // AW addresses the memory, CW holds a count up to MAX_ENTRIES,
  // CMPW is wide enough for every compare (count, 6-bit fields, limits).
  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  state_t state, state_next;

  // control state
  logic [CW-1:0]    count;
  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    src_ptr;   // shift read pointer, also the dump pointer
  logic [CW-1:0]    dst_ptr;   // shift write pointer
  logic             rd_pend;   // a shift read is returning this cycle

  // payload
  status_t              rsp_status;
  logic [ELEM_W-1:0]    mem [MAX_ENTRIES];
  logic [ELEM_W-1:0]    rd_data;
  clb_res_t             res_next;

  // memory port controls
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [ELEM_W-1:0]    mem_wd;
  logic                 mem_re;
  logic [AW-1:0]        mem_ra;

  logic res_load;
  logic out_free;
  logic cmd_acc;

  logic [CMPW-1:0] count_x, pos_x, endp_x, cap_eff, src_x;
  logic            src_lt;
  logic            dump_last;

  // decode of the incoming command
  status_t         dec_status;
  logic            dec_push, dec_pop, dec_shift, dec_dump;
  logic [CMPW-1:0] dec_from, dec_to;

  assign cfg_ready = 1'b1;
  assign cmd_acc   = cmd_valid && (state == S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  assign count_x = CMPW'(count);
  assign pos_x   = CMPW'(cmd.position);
  assign endp_x  = CMPW'(cmd.end_position);
  assign src_x   = CMPW'(src_ptr);

  assign src_lt    = src_x < count_x;
  assign dump_last = (src_x + CMPW'(1)) == count_x;

  // capacity register clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cap == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap) > CMPW'(MAX_ENTRIES)) begin
      cap_eff = CMPW'(MAX_ENTRIES);
    end else begin
      cap_eff = CMPW'(cap);
    end
  end

  // command decoder: a failing check leaves everything untouched
  always_comb begin
    dec_status = ST_OK;
    dec_push   = 1'b0;
    dec_pop    = 1'b0;
    dec_shift  = 1'b0;
    dec_dump   = 1'b0;
    dec_from   = '0;
    dec_to     = '0;
    unique case (cmd.command)
      OP_PUSH: begin
        if (count_x >= cap_eff) dec_status = ST_FULL;
        else dec_push = 1'b1;
      end
      OP_POP_TAIL: begin
        if (count == '0) dec_status = ST_EMPTY;
        else dec_pop = 1'b1;
      end
      OP_POP_HEAD: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_shift = 1'b1;
          dec_to    = CMPW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= count_x) begin
          dec_status = ST_BAD;
        end else begin
          dec_shift = 1'b1;
          dec_from  = pos_x;
          dec_to    = pos_x + CMPW'(1);
        end
      end
      OP_ERASE: begin
        if (!(pos_x < endp_x && endp_x <= count_x)) begin
          dec_status = ST_BAD;
        end else begin
          dec_shift = 1'b1;
          dec_from  = pos_x;
          dec_to    = endp_x;
        end
      end
      OP_DUMP: begin
        dec_dump = (count != '0);
      end
      default: begin
        // unused codes: ok, no change
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          if (dec_shift)     state_next = S_SHIFT;
          else if (dec_dump) state_next = S_DUMP_RD;
          else               state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        if (!src_lt && !rd_pend) state_next = S_RESP;
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_WAIT;
      end
      S_DUMP_WAIT: begin
        if (out_free) state_next = dump_last ? S_IDLE : S_DUMP_RD;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: memory controls and result loading
  always_comb begin
    cmd_stall = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_wa    = count[AW-1:0];
    mem_wd    = cmd.element_value;
    mem_re    = 1'b0;
    mem_ra    = src_ptr[AW-1:0];
    res_load  = 1'b0;
    res_next  = '0;
    res_next.count    = count_x[5:0];
    res_next.is_empty = (count == '0);
    res_next.last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        mem_we = cmd_acc && dec_push;
      end
      S_SHIFT: begin
        // read at src, write the previous read back at dst; dst always trails src
        mem_re = src_lt;
        mem_we = rd_pend;
        mem_wa = dst_ptr[AW-1:0];
        mem_wd = rd_data;
      end
      S_DUMP_RD: begin
        mem_re = 1'b1;
      end
      S_DUMP_WAIT: begin
        res_load               = out_free;
        res_next.status        = ST_OK;
        res_next.element_out   = rd_data;
        res_next.element_valid = 1'b1;
        res_next.last          = dump_last;
      end
      S_RESP: begin
        res_load        = out_free;
        res_next.status = rsp_status;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CAPACITY_RESET;
      src_ptr   <= '0;
      dst_ptr   <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) cap <= cfg_data;

      if (res_load)        res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (dec_push) count <= count + CW'(1);
            if (dec_pop)  count <= count - CW'(1);
            src_ptr <= CW'(dec_to);
            dst_ptr <= CW'(dec_from);
            rd_pend <= 1'b0;
          end
        end
        S_SHIFT: begin
          rd_pend <= src_lt;
          if (src_lt)  src_ptr <= src_ptr + CW'(1);
          if (rd_pend) dst_ptr <= dst_ptr + CW'(1);
          // final dst is the new count: from + (count - to)
          if (!src_lt && !rd_pend) count <= dst_ptr;
        end
        S_DUMP_WAIT: begin
          if (out_free) src_ptr <= src_ptr + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_acc) rsp_status <= dec_status;
    if (res_load) res <= res_next;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

endmodule

`default_nettype wire

// ----- rtl/core/clb_checker.sv -----
`default_nettype none

module clb_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input logic              res_valid,
  input logic              res_stall,
  input clb_pkg::clb_res_t res
);

  import clb_pkg::*;

  // a held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.is_empty == (res.count == 6'd0))
    else $error("empty flag disagrees with count");

  // streamed elements come only from a non-empty list with ok status
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.element_valid |-> res.status == ST_OK && !res.is_empty)
    else $error("element on error or empty list");

  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.element_valid |-> res.element_out == '0 && res.last)
    else $error("non-element result not final or not zero");

  // the core never accepts two commands back to back
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("core took a command back to back");

endmodule

bind compacting_list_buffer clb_checker u_clb_checker (.*);

`default_nettype wire
